// ===== hdl/fcr_pkg.sv =====
// Shared types, codes and helpers for the Fletcher-checked frame receiver.
// No dependencies; imported by fcr_parser and the core top level.
package fcr_pkg;

  // Power-on value of the sync byte register
  localparam logic [7:0] SYNC_RESET = 8'hA5;

  // Modulus of both running sums
  localparam logic [8:0] MOD_VAL = 9'd255;

  // Frame parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ID   = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CKSUM  = 2'd1,
    ST_HEADER = 2'd2
  } status_t;

  // One result beat as it leaves the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] body_byte;
    logic       has_byte;
    logic       frame_end;
    status_t    status;
  } result_t;

  // Add modulo 255; a is below 255, b any byte, so one subtract suffices
  function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= MOD_VAL) begin
      sum = sum - MOD_VAL;
    end
    return sum[7:0];
  endfunction

endpackage

// ===== hdl/fletcher_checked_frame_receiver_core.sv =====
// Channel  | Ports                                        | Moves
// ---------+----------------------------------------------+-------------------------
// input    | in_valid, in_stall, in_rx_byte               | one link byte per beat
// result   | out_valid, out_stall, out_body_byte,         | zero or one result beat
//          | out_has_byte, out_frame_end, out_status      | per input beat
// config   | cfg_wr_en, cfg_wr_data                       | sync byte register write
//
// One byte per cycle sustained while the result side does not stall; each beat passes
// through the input register, then the parser logic into the result register.
// Reset (rst_n low, synchronous) empties both registers, puts the parser in hunt
// and loads the sync register with 0xA5.
// A stall on the result side holds a full result register; a full input register then
// holds and in_stall rises in the same cycle.
// Top level: sync register, input register, parser, result register.
// Depends on fcr_pkg and fcr_parser.
module fletcher_checked_frame_receiver_core
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_body_byte,
  output logic       out_has_byte,
  output logic       out_frame_end,
  output logic [1:0] out_status
);

  logic [7:0] sync_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  result_t    res_r;
  result_t    res_c;
  logic       out_free;
  logic       step;
  logic       in_take;

  // Result register can load when empty or being taken this cycle
  assign out_free = !res_r.valid || !out_stall;
  assign step     = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Sync byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  fcr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .sync_value (sync_r),
    .res        (res_c)
  );

  // Result register: load a new beat or drop the one taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (out_free) begin
      res_r.valid <= step && res_c.valid;
    end
    if (step) begin
      res_r.body_byte <= res_c.body_byte;
      res_r.has_byte  <= res_c.has_byte;
      res_r.frame_end <= res_c.frame_end;
      res_r.status    <= res_c.status;
    end
  end

  assign out_valid     = res_r.valid;
  assign out_body_byte = res_r.body_byte;
  assign out_has_byte  = res_r.has_byte;
  assign out_frame_end = res_r.frame_end;
  assign out_status    = res_r.status;

`ifndef SYNTH
  // Input side stalls only while holding a beat the result side cannot take
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && res_r.valid && out_stall))
    else $error("in_stall without a blocked beat");

  // Mid-frame results carry ok status and a body byte
  a_mid_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (out_has_byte && out_status == ST_OK))
    else $error("mid-frame result with bad status or no byte");

  // Bad header results never carry a byte
  a_header_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_HEADER) |-> (!out_has_byte && out_frame_end))
    else $error("bad header result carries a byte");

  // A stalled input beat is not processed, so the result register keeps its beat
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_body_byte)
      && $stable(out_status)))
    else $error("stalled result changed");
`endif

endmodule

// ===== hdl/fcr_parser.sv =====
// Frame parser: phase, length counter and the two mod-255 running sums.
// Depends on fcr_pkg for phase_t, status_t, result_t and mod255_add.
module fcr_parser
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_value,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] sum_first_r, sum_first_nxt;
  logic [7:0] sum_second_r, sum_second_nxt;

  // Sums after folding in this byte; a new frame restarts from zero
  logic [7:0] base_first, base_second;
  logic [7:0] acc_first, acc_second;
  logic [8:0] check_sum;
  logic       check_ok;
  logic [7:0] left_dec;

  always_comb begin
    base_first  = (phase_r == PH_HUNT) ? 8'd0 : sum_first_r;
    base_second = (phase_r == PH_HUNT) ? 8'd0 : sum_second_r;
    acc_first   = mod255_add(base_first, rx_byte);
    acc_second  = mod255_add(base_second, acc_first);
    check_sum   = {1'b0, acc_first} + {1'b0, acc_second};
    check_ok    = (check_sum == 9'd0) || (check_sum == MOD_VAL);
    left_dec    = bytes_left_r - 8'd1;
  end

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    sum_first_nxt  = sum_first_r;
    sum_second_nxt = sum_second_r;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == sync_value) begin
          phase_nxt      = PH_ID;
          sum_first_nxt  = acc_first;
          sum_second_nxt = acc_second;
        end
      end
      PH_ID: begin
        phase_nxt      = PH_LEN;
        sum_first_nxt  = acc_first;
        sum_second_nxt = acc_second;
      end
      PH_LEN: begin
        bytes_left_nxt = rx_byte;
        sum_first_nxt  = acc_first;
        sum_second_nxt = acc_second;
        phase_nxt      = (rx_byte == 8'd0) ? PH_HUNT : PH_BODY;
      end
      PH_BODY: begin
        bytes_left_nxt = left_dec;
        sum_first_nxt  = acc_first;
        sum_second_nxt = acc_second;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Result for this byte
  always_comb begin
    res = '{valid: 1'b0, body_byte: 8'd0, has_byte: 1'b0, frame_end: 1'b0, status: ST_OK};
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte != sync_value) begin
          res.valid     = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_HEADER;
        end
      end
      PH_ID: begin
        res.valid = 1'b0;
      end
      PH_LEN: begin
        if (rx_byte == 8'd0) begin
          res.valid     = 1'b1;
          res.frame_end = 1'b1;
          res.status    = check_ok ? ST_OK : ST_CKSUM;
        end
      end
      PH_BODY: begin
        res.valid     = 1'b1;
        res.body_byte = rx_byte;
        res.has_byte  = 1'b1;
        if (left_dec == 8'd0) begin
          res.frame_end = 1'b1;
          res.status    = check_ok ? ST_OK : ST_CKSUM;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  // Advance state on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_left_r <= 8'd0;
      sum_first_r  <= 8'd0;
      sum_second_r <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_first_r  <= sum_first_nxt;
      sum_second_r <= sum_second_nxt;
    end
  end

endmodule
